// File: src/fpls_pkg.sv
package fpls_pkg;

  localparam logic [3:0] LED_ALL     = 4'hF;
  localparam logic [3:0] LED_EXTRACT = 4'h8;
  localparam logic [2:0] TICKS_500MS = 3'd5;
  localparam logic [1:0] CHASE_TICKS = 2'd3;
  localparam logic [4:0] FLICKER_END = 5'd15;
  localparam logic [2:0] CHASE_TOP   = 3'd4;
  localparam logic [2:0] BLINK_STEPS = 3'd6;
  localparam logic [2:0] CUP_HALF    = 3'd1;
  localparam logic [2:0] CUP_ONE     = 3'd2;

  // flicker toggles where flicker_ticks % 5 == 1 within 1..15
  localparam logic [4:0] FLICK_T0 = 5'd1;
  localparam logic [4:0] FLICK_T1 = 5'd6;
  localparam logic [4:0] FLICK_T2 = 5'd11;

  typedef enum logic [1:0] {
    PH_BLINK = 2'd0,
    PH_PAUSE = 2'd1,
    PH_SHOW  = 2'd2,
    PH_DARK  = 2'd3
  } ver_phase_t;

  typedef struct packed {
    logic       water_out;
    logic       continuous_mode;
    logic [2:0] cup_level;
    logic       cup_level_changed;
    logic       error_present;
    logic       leak_error;
    logic       high_level_error;
    logic       feed_valve_error;
  } tick_t;

  typedef struct packed {
    logic       version_done;
    ver_phase_t version_phase;
    logic [2:0] version_ticks;
    logic [2:0] version_blinks;
    logic [3:0] led_register;
    logic [2:0] wink_count;
    logic       wink_flag;
    logic       flicker_active;
    logic [4:0] flicker_ticks;
    logic       flicker_level;
    logic [2:0] extract_ticks;
    logic [1:0] chase_ticks;
    logic [2:0] chase_position;
  } seq_state_t;

  function automatic logic [3:0] version_pattern(input logic [3:0] major);
    logic [3:0] p;
    begin
      unique case (major)
        4'd1:    p = 4'h1;
        4'd2:    p = 4'h2;
        4'd3:    p = 4'h4;
        4'd4:    p = 4'h8;
        4'd5:    p = 4'h3;
        4'd6:    p = 4'h5;
        default: p = 4'h6;
      endcase
      return p;
    end
  endfunction

endpackage

// File: src/fpls_step.sv
// Next-state and LED pattern for one tick.
module fpls_step (
  input  fpls_pkg::seq_state_t st,
  input  fpls_pkg::tick_t      tick,
  input  logic [3:0]           version_major,
  output fpls_pkg::seq_state_t st_next
);

  fpls_pkg::seq_state_t s;

  always_comb begin
    s = st;

    if (tick.cup_level_changed) begin
      s.flicker_active = 1'b1;
    end

    // 500 ms winker
    s.wink_count = s.wink_count + 3'd1;
    if (s.wink_count >= fpls_pkg::TICKS_500MS) begin
      s.wink_count = 3'd0;
      s.wink_flag  = ~s.wink_flag;
    end

    // double flicker timer
    if (s.flicker_active) begin
      s.flicker_ticks = s.flicker_ticks + 5'd1;
      if (s.flicker_ticks > fpls_pkg::FLICKER_END) begin
        s.flicker_active = 1'b0;
        s.flicker_level  = 1'b1;
      end else if (s.flicker_ticks == fpls_pkg::FLICK_T0 ||
                   s.flicker_ticks == fpls_pkg::FLICK_T1 ||
                   s.flicker_ticks == fpls_pkg::FLICK_T2) begin
        s.flicker_level = ~s.flicker_level;
      end
    end else begin
      s.flicker_ticks = 5'd0;
      s.flicker_level = 1'b1;
    end

    if (!s.version_done) begin
      s.version_ticks = s.version_ticks + 3'd1;
      unique case (s.version_phase)
        fpls_pkg::PH_BLINK: begin
          if (s.version_ticks >= fpls_pkg::TICKS_500MS) begin
            s.version_ticks  = 3'd0;
            s.version_blinks = s.version_blinks + 3'd1;
            s.led_register   = s.version_blinks[0] ? 4'h0 : fpls_pkg::LED_ALL;
            if (s.version_blinks > fpls_pkg::BLINK_STEPS) begin
              s.version_phase  = fpls_pkg::PH_PAUSE;
              s.version_blinks = 3'd0;
            end
          end
        end
        fpls_pkg::PH_PAUSE: begin
          if (s.version_ticks >= fpls_pkg::TICKS_500MS) begin
            s.version_ticks = 3'd0;
            s.version_phase = fpls_pkg::PH_SHOW;
          end
        end
        fpls_pkg::PH_SHOW: begin
          s.led_register = s.led_register | fpls_pkg::version_pattern(version_major);
          if (s.version_ticks >= fpls_pkg::TICKS_500MS) begin
            s.version_ticks = 3'd0;
            s.version_phase = fpls_pkg::PH_DARK;
          end
        end
        fpls_pkg::PH_DARK: begin
          s.led_register = 4'h0;
          if (s.version_ticks >= fpls_pkg::TICKS_500MS) begin
            s.version_ticks = 3'd0;
            s.version_phase = fpls_pkg::PH_BLINK;
            s.version_done  = 1'b1;
          end
        end
      endcase
    end else begin
      // extract LED
      if (tick.water_out) begin
        if (tick.continuous_mode) begin
          s.led_register[3] = 1'b1;
        end else begin
          s.extract_ticks = s.extract_ticks + 3'd1;
          if (s.extract_ticks >= fpls_pkg::TICKS_500MS) begin
            s.extract_ticks = 3'd0;
            s.led_register  = s.led_register ^ fpls_pkg::LED_EXTRACT;
          end
        end
      end else begin
        s.led_register[3] = 1'b1;
        s.extract_ticks   = 3'd0;
      end

      // cup LEDs: chase or selected level
      if (tick.water_out && tick.continuous_mode) begin
        s.chase_ticks = s.chase_ticks + 2'd1;
        if (s.chase_ticks >= fpls_pkg::CHASE_TICKS) begin
          s.chase_ticks = 2'd0;
          if (s.chase_position == fpls_pkg::CHASE_TOP) begin
            s.chase_position = 3'd1;
          end else begin
            s.chase_position = {s.chase_position[1:0], 1'b0};
          end
          s.led_register = (s.led_register & fpls_pkg::LED_EXTRACT) |
                           {1'b0, s.chase_position};
        end
      end else begin
        s.chase_ticks    = 2'd0;
        s.chase_position = tick.cup_level;
        s.led_register   = s.led_register & fpls_pkg::LED_EXTRACT;
        priority if (tick.cup_level == fpls_pkg::CUP_HALF) begin
          s.led_register[0] = s.flicker_level;
        end else if (tick.cup_level == fpls_pkg::CUP_ONE) begin
          s.led_register[1] = s.flicker_level;
        end else begin
          s.led_register[2] = s.flicker_level;
        end
      end

      // error wink, first active error wins; no error bit leaves the display as is
      if (tick.error_present && !tick.continuous_mode) begin
        if (tick.leak_error) begin
          s.led_register[0] = s.wink_flag;
        end else if (tick.high_level_error) begin
          s.led_register[1] = s.wink_flag;
        end else if (tick.feed_valve_error) begin
          s.led_register[2] = s.wink_flag;
        end
      end
    end

    st_next = s;
  end

endmodule

// File: src/front_panel_led_sequencer_top.sv
// Front-panel LED sequencer. Each slave-side transfer is one 100 ms status
// tick and yields exactly one master-side transfer with the new state of the
// four LEDs (bit0 half cup, bit1 one cup, bit2 two cup, bit3 extract). After
// reset a version sequence plays (blinks, pause, version pattern from the
// version_major register at byte address 0, dark), then normal display runs:
// extract LED, cup level with a double flicker after a level change, a chase
// during continuous dispensing, and a 500 ms wink of the first active error.
// A tick's result is registered when the tick is accepted; the state update
// is one combinational pass into the state and result registers, so a new
// tick is taken every cycle as long as the result register is empty or
// being drained in the same cycle.
module front_panel_led_sequencer_top (
  input  logic        clk,
  input  logic        rst,

  // status ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] water_out, [1] continuous_mode, [4:2] cup_level,
  // [5] cup_level_changed, [6] error_present, [7] leak_error,
  // [8] high_level_error, [9] feed_valve_error, [15:10] zero
  input  logic [15:0] s_tdata,

  // LED results
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] led_pattern, [7:4] zero
  output logic [7:0]  m_tdata,

  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_VERSION_MAJOR = 1'b0;  // paddr[2] of register 0

  fpls_pkg::seq_state_t st;
  fpls_pkg::seq_state_t st_next;
  fpls_pkg::tick_t      tick;
  logic [3:0]           version_major;
  logic [3:0]           led_out;
  logic                 s_xfer;

  // unpack tick fields
  assign tick.water_out         = s_tdata[0];
  assign tick.continuous_mode   = s_tdata[1];
  assign tick.cup_level         = s_tdata[4:2];
  assign tick.cup_level_changed = s_tdata[5];
  assign tick.error_present     = s_tdata[6];
  assign tick.leak_error        = s_tdata[7];
  assign tick.high_level_error  = s_tdata[8];
  assign tick.feed_valve_error  = s_tdata[9];

  // result register parts the two sides: refill while draining
  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;

  fpls_step u_step (
    .st            (st),
    .tick          (tick),
    .version_major (version_major),
    .st_next       (st_next)
  );

  // sequencer state, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s_xfer) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      led_out <= st_next.led_register;
    end
  end

  assign m_tdata = {4'h0, led_out};

  // APB register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      version_major <= 4'd1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_VERSION_MAJOR) begin
      version_major <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_VERSION_MAJOR) ? {28'h0, version_major} : 32'h0;

endmodule

// File: tb/sv/led_pattern_checker.sv
`timescale 1ns / 100ps

module led_pattern_checker #(
  parameter logic [2:0] REG_VERSION = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);

  // predicted sequencer state
  logic [3:0] ver_major;
  logic       ver_done;
  fpls_pkg::ver_phase_t ver_ph;
  logic [2:0] ver_tk;
  logic [2:0] ver_bl;
  logic [3:0] leds;
  logic [2:0] wink_cnt;
  logic       wink_on;
  logic       flk_act;
  logic [4:0] flk_tk;
  logic       flk_lvl;
  logic [2:0] ext_tk;
  logic [1:0] chs_tk;
  logic [2:0] chs_pos;

  logic [3:0] expected_leds[$];
  int         fail_cnt = 0;

  // one status tick -> new LED state
  function automatic logic [3:0] next_led_pattern(input logic [9:0] t);
    logic       water, cont, chg, err, leak, high, feed;
    logic [2:0] cup;
    water = t[0];
    cont  = t[1];
    cup   = t[4:2];
    chg   = t[5];
    err   = t[6];
    leak  = t[7];
    high  = t[8];
    feed  = t[9];

    if (chg) flk_act = 1'b1;

    // 500 ms winker and flicker timer run on every tick
    wink_cnt = wink_cnt + 3'd1;
    if (wink_cnt >= fpls_pkg::TICKS_500MS) begin
      wink_cnt = '0;
      wink_on  = ~wink_on;
    end
    if (flk_act) begin
      flk_tk = flk_tk + 5'd1;
      if (flk_tk > fpls_pkg::FLICKER_END) begin
        flk_act = 1'b0;
        flk_lvl = 1'b1;
      end else if ((flk_tk % fpls_pkg::TICKS_500MS) == 5'd1) begin
        flk_lvl = ~flk_lvl;
      end
    end else begin
      flk_tk  = '0;
      flk_lvl = 1'b1;
    end

    if (!ver_done) begin
      ver_tk = ver_tk + 3'd1;
      case (ver_ph)
        fpls_pkg::PH_BLINK: begin
          if (ver_tk >= fpls_pkg::TICKS_500MS) begin
            ver_tk = '0;
            ver_bl = ver_bl + 3'd1;
            leds   = ver_bl[0] ? 4'h0 : fpls_pkg::LED_ALL;
            if (ver_bl > fpls_pkg::BLINK_STEPS) begin
              ver_ph = fpls_pkg::PH_PAUSE;
              ver_bl = '0;
            end
          end
        end
        fpls_pkg::PH_PAUSE: begin
          if (ver_tk >= fpls_pkg::TICKS_500MS) begin
            ver_tk = '0;
            ver_ph = fpls_pkg::PH_SHOW;
          end
        end
        fpls_pkg::PH_SHOW: begin
          case (ver_major)
            4'd1:    leds = leds | 4'h1;
            4'd2:    leds = leds | 4'h2;
            4'd3:    leds = leds | 4'h4;
            4'd4:    leds = leds | 4'h8;
            4'd5:    leds = leds | 4'h3;
            4'd6:    leds = leds | 4'h5;
            default: leds = leds | 4'h6;
          endcase
          if (ver_tk >= fpls_pkg::TICKS_500MS) begin
            ver_tk = '0;
            ver_ph = fpls_pkg::PH_DARK;
          end
        end
        default: begin
          leds = 4'h0;
          if (ver_tk >= fpls_pkg::TICKS_500MS) begin
            ver_tk   = '0;
            ver_ph   = fpls_pkg::PH_BLINK;
            ver_done = 1'b1;
          end
        end
      endcase
    end else begin
      // extract LED
      if (water) begin
        if (cont) begin
          leds[3] = 1'b1;
        end else begin
          ext_tk = ext_tk + 3'd1;
          if (ext_tk >= fpls_pkg::TICKS_500MS) begin
            ext_tk  = '0;
            leds[3] = ~leds[3];
          end
        end
      end else begin
        leds[3] = 1'b1;
        ext_tk  = '0;
      end

      // cup LEDs: chase or selected level
      if (water && cont) begin
        chs_tk = chs_tk + 2'd1;
        if (chs_tk >= fpls_pkg::CHASE_TICKS) begin
          chs_tk    = '0;
          chs_pos   = (chs_pos == fpls_pkg::CHASE_TOP) ? 3'd1 : {chs_pos[1:0], 1'b0};
          leds[2:0] = chs_pos;
        end
      end else begin
        chs_tk    = '0;
        chs_pos   = cup;
        leds[2:0] = 3'b000;
        if (cup == fpls_pkg::CUP_HALF)     leds[0] = flk_lvl;
        else if (cup == fpls_pkg::CUP_ONE) leds[1] = flk_lvl;
        else                               leds[2] = flk_lvl;
      end

      // first active error winks over the cup display
      if (err && !cont) begin
        if (leak)      leds[0] = wink_on;
        else if (high) leds[1] = wink_on;
        else if (feed) leds[2] = wink_on;
      end
    end
    return leds;
  endfunction

  always @(posedge clk) begin : watch
    logic [3:0] want;
    if (rst) begin
      ver_major = 4'd1;
      ver_done  = 1'b0;
      ver_ph    = fpls_pkg::PH_BLINK;
      ver_tk    = '0;
      ver_bl    = '0;
      leds      = '0;
      wink_cnt  = '0;
      wink_on   = 1'b0;
      flk_act   = 1'b0;
      flk_tk    = '0;
      flk_lvl   = 1'b0;
      ext_tk    = '0;
      chs_tk    = '0;
      chs_pos   = '0;
      expected_leds.delete();
    end else begin
      // a tick taken at the same edge as a register write still sees the old value
      if (s_tvalid && s_tready)
        expected_leds.push_back(next_led_pattern(s_tdata[9:0]));
      if (psel && penable && pwrite && pready && paddr == REG_VERSION)
        ver_major = pwdata[3:0];
      if (m_tvalid && m_tready) begin
        if (expected_leds.size() == 0) begin
          fail_cnt++;
          $error("led_pattern: unexpected transfer, expected none actual %h", m_tdata[3:0]);
        end else begin
          want = expected_leds.pop_front();
          if (m_tdata[3:0] !== want) begin
            fail_cnt++;
            $error("led_pattern: expected %h actual %h", want, m_tdata[3:0]);
          end
        end
      end
    end
    pending <= expected_leds.size();
    fails   <= fail_cnt;
  end

endmodule

// File: tb/sv/tb_front_panel_led_sequencer_top.sv
`timescale 1ns / 100ps

module tb_front_panel_led_sequencer_top;

  // byte address of version_major
  localparam logic [2:0] REG_VERSION = 3'd0;
  // cycles with no transfer at all before the run is given up
  localparam int IDLE_LIMIT = 2000;
  // long receiver hold-off, long enough to back up the input side
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 6;
  localparam int PHASE_TICKS = 245;
  localparam int STARTUP_TICKS = 56;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int pending;
  int burst_left = 0;
  bit hold_req = 1'b0;

  // current appliance status; random ticks mostly repeat it with small edits
  logic       sc_water = 1'b0;
  logic       sc_cont  = 1'b0;
  logic [2:0] sc_cup   = 3'd1;
  logic       sc_err   = 1'b0;
  logic       sc_leak  = 1'b0;
  logic       sc_high  = 1'b0;
  logic       sc_feed  = 1'b0;

  front_panel_led_sequencer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  led_pattern_checker #(.REG_VERSION(REG_VERSION)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // tdata layout, low bit first: water, cont, cup[2:0], changed, err, leak, high, feed
  function automatic logic [9:0] pack_tick(input logic water, input logic cont,
                                           input logic [2:0] cup, input logic chg,
                                           input logic err, input logic leak,
                                           input logic high, input logic feed);
    return {feed, high, leak, err, chg, cup, cont, water};
  endfunction

  // mostly one-hot cup codes, sometimes any code (0, 3, 5..7 shown as two cup)
  function automatic logic [2:0] pick_cup();
    if ($urandom_range(0, 3) == 0) return 3'($urandom_range(0, 7));
    return 3'd1 << $urandom_range(0, 2);
  endfunction

  // Random tick: runs of a held status so the chase, the flicker, the extract
  // toggle and the error wink get to play out; a slice of pure noise on top.
  function automatic logic [9:0] random_tick();
    logic chg;
    chg = 1'b0;
    if ($urandom_range(0, 14) == 0) return 10'($urandom);
    if ($urandom_range(0, 29) == 0) begin
      sc_water = 1'($urandom_range(0, 1));
      sc_cont  = 1'($urandom_range(0, 1));
      sc_err   = ($urandom_range(0, 2) == 0);
      sc_leak  = 1'($urandom_range(0, 1));
      sc_high  = 1'($urandom_range(0, 1));
      sc_feed  = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 24) == 0) begin
      sc_cup = pick_cup();
      chg    = ($urandom_range(0, 5) != 0);
    end else if ($urandom_range(0, 49) == 0) begin
      chg = 1'b1;
    end
    return pack_tick(sc_water, sc_cont, sc_cup, chg, sc_err, sc_leak, sc_high, sc_feed);
  endfunction

  // Offer one tick and wait for its transfer. Bursts of random length with
  // random gaps; valid stays high across a burst.
  task automatic send_tick(input logic [9:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering and let every expected result drain. The first edge lets
  // the checker count a tick taken at the edge we were called on.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // setup cycle, then access cycle until pready
  task automatic write_version(input logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_VERSION;
    pwdata  <= {28'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: stalls on a changing pattern, plus one long hold-off on request.
  initial begin : rx_side
    int mode;
    int mode_left;
    int cyc;
    mode      = 0;
    mode_left = 0;
    cyc       = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      cyc++;
      case (mode)
        0:       m_tready <= 1'b1;                       // never stalls
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
        default: m_tready <= (cyc % 3 != 0);
      endcase
    end
  end

  // Watchdog: any transfer on either stream or the config port resets it.
  initial begin : watchdog
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        idle_cnt = 0;
      else
        idle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int i;
    int k;
    int pass_idx;
    logic [3:0] ver;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_version(4'd0);  // unknown version, shows the fallback pattern

    // Power-up sequence: blinks, pause, pattern, dark, about 50 ticks.
    // Around the pattern window the version is rewritten before every tick,
    // so each pattern tick ORs in a fresh value; the top value lands there too.
    for (i = 0; i < STARTUP_TICKS; i++) begin
      if (i >= 36 && i <= 46) begin
        wait_idle();
        ver = (i == 41) ? 4'hF : 4'($urandom_range(0, 15));
        write_version(ver);
      end
      send_tick(random_tick());
    end

    // Directed ticks in normal mode.
    send_tick(pack_tick(0, 0, 3'd0, 0, 0, 0, 0, 0));  // all zero, unknown cup 0
    send_tick(10'h3FF);                               // every field at its top
    send_tick(pack_tick(0, 0, 3'd1, 1, 0, 0, 0, 0));  // start flicker on half cup
    send_tick(pack_tick(0, 0, 3'd2, 1, 0, 0, 0, 0));  // new pulse while flickering
    send_tick(pack_tick(0, 0, 3'd0, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 3'd7, 0, 0, 0, 0, 0));  // unknown cup code
    send_tick(pack_tick(0, 0, 3'd3, 0, 0, 0, 0, 0));  // load odd chase start
    repeat (4) send_tick(pack_tick(1, 1, 3'd3, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 3'd0, 0, 0, 0, 0, 0));  // load chase start of zero
    repeat (3) send_tick(pack_tick(1, 1, 3'd0, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 3'd1, 0, 1, 1, 1, 1));  // leak wins
    send_tick(pack_tick(0, 0, 3'd1, 0, 1, 0, 1, 1));  // high level next
    send_tick(pack_tick(0, 0, 3'd1, 0, 1, 0, 0, 1));  // feed valve last
    send_tick(pack_tick(0, 0, 3'd1, 0, 0, 1, 1, 1));  // error bits, no error_present
    send_tick(pack_tick(1, 1, 3'd2, 0, 1, 1, 0, 0));  // error during continuous
    repeat (5) send_tick(pack_tick(1, 0, 3'd4, 0, 0, 0, 0, 0));  // extract toggle

    // Random phases, version rewritten between them while idle.
    for (pass_idx = 0; pass_idx < PHASES; pass_idx++) begin
      wait_idle();
      case (pass_idx)
        0:       ver = 4'hF;
        1:       ver = 4'h0;
        2:       ver = 4'd6;
        default: ver = 4'($urandom_range(0, 15));
      endcase
      write_version(ver);
      for (k = 0; k < PHASE_TICKS; k++) begin
        if (pass_idx == 1 && k == 100) hold_req = 1'b1;  // back up the whole pipe
        send_tick(random_tick());
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
